/* rtl/core/jptz_pkg.sv */
// Shared types, codes and constants of the joystick to PTZ command translator.
`default_nettype none
package jptz_pkg;

    localparam int AXIS_W        = 16;
    localparam int HAT_W         = 4;
    localparam int BUTTON_W      = 12;
    localparam int SPEED_W       = 15;
    localparam int DIR_W         = 4;
    localparam int ZOOM_W        = 2;
    localparam int PRESET_W      = 8;
    localparam int KIND_W        = 2;
    localparam int CMD_SLOTS     = 4;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 32;
    localparam int DEF_BUTTON_COUNT = 12;
    localparam int DEF_QUEUE_DEPTH  = 4;

    localparam logic [KIND_W-1:0] KIND_ROTATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZOOM   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RECALL = 2'd3;

    localparam logic [DIR_W-1:0] DIR_STOP       = 4'd0;
    localparam logic [DIR_W-1:0] DIR_UP         = 4'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd4;
    localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd5;
    localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd6;
    localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd7;
    localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd8;

    localparam logic [ZOOM_W-1:0] ZOOM_STOP = 2'd0;
    localparam logic [ZOOM_W-1:0] ZOOM_TELE = 2'd1;
    localparam logic [ZOOM_W-1:0] ZOOM_WIDE = 2'd2;

    // Bits of the pending command mask, in emission order.
    localparam int SLOT_ROTATE = 0;
    localparam int SLOT_ZOOM   = 1;
    localparam int SLOT_STOP   = 2;
    localparam int SLOT_RECALL = 3;

    typedef struct packed {
        logic [CMD_SLOTS-1:0] mask;
        logic [DIR_W-1:0]     dir;
        logic [SPEED_W-1:0]   speed;
        logic [ZOOM_W-1:0]    zoom;
        logic [PRESET_W-1:0]  preset;
    } t_cmd_set;

endpackage
`default_nettype wire

/* rtl/core/jptz_front.sv */
// Front end: takes joystick polls, compares with the previous poll and builds command sets.
`default_nettype none
module jptz_front
    import jptz_pkg::*;
#(
    parameter int BUTTON_COUNT = DEF_BUTTON_COUNT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [PRESET_W-1:0]   i_cfg_wr_data,
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire logic [IN_DATA_W-1:0]  i_data,
    input  wire logic                  i_q_full,
    output      logic                  o_push,
    output      t_cmd_set              o_set
);

    localparam int WATCHED = (BUTTON_COUNT < BUTTON_W) ? BUTTON_COUNT : BUTTON_W;

    logic [PRESET_W-1:0] r_home_preset;
    logic [AXIS_W-1:0]   r_prev_pan;
    logic [AXIS_W-1:0]   r_prev_tilt;
    logic [SPEED_W-1:0]  r_prev_speed;
    logic [HAT_W-1:0]    r_prev_hat;
    logic [WATCHED-1:0]  r_prev_buttons;

    logic [AXIS_W-1:0]   pan;
    logic [AXIS_W-1:0]   tilt;
    logic [AXIS_W-1:0]   thr;
    logic [HAT_W-1:0]    hat;
    logic [WATCHED-1:0]  buttons;
    logic [WATCHED-1:0]  rising;
    logic [SPEED_W-1:0]  speed;
    logic                accept;
    logic                recall_hit;
    logic [3:0]          recall_idx;
    logic [1:0]          pan_sign;
    logic [1:0]          tilt_sign;

    assign pan     = i_data[AXIS_W-1:0];
    assign tilt    = i_data[2*AXIS_W-1:AXIS_W];
    assign thr     = i_data[3*AXIS_W-1:2*AXIS_W];
    assign hat     = i_data[3*AXIS_W+HAT_W-1:3*AXIS_W];
    assign buttons = i_data[3*AXIS_W+HAT_W+WATCHED-1:3*AXIS_W+HAT_W];
    assign rising  = buttons & ~r_prev_buttons;

    // The speed is (32767 - throttle) >> 1, which is the inverted offset-binary value shifted.
    assign speed = {thr[AXIS_W-1], ~thr[AXIS_W-2:1]};

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Sign codes: bit 1 is negative, bit 0 is positive.
    assign pan_sign  = {pan[AXIS_W-1], (pan != '0) && !pan[AXIS_W-1]};
    assign tilt_sign = {tilt[AXIS_W-1], (tilt != '0) && !tilt[AXIS_W-1]};

    always_comb begin
        recall_hit = 1'b0;
        recall_idx = '0;
        for (int k = WATCHED - 1; k >= 1; k--) begin
            if (rising[k]) begin
                recall_hit = 1'b1;
                recall_idx = 4'(k);
            end
        end
    end

    always_comb begin
        o_set = '0;
        o_set.mask[SLOT_ROTATE] = (pan != r_prev_pan) || (tilt != r_prev_tilt) ||
                                  (speed != r_prev_speed);
        o_set.mask[SLOT_ZOOM]   = (hat != r_prev_hat);
        o_set.mask[SLOT_STOP]   = rising[0];
        o_set.mask[SLOT_RECALL] = recall_hit;
        o_set.speed = speed;
        if (pan_sign[1]) begin
            o_set.dir = tilt_sign[1] ? DIR_DOWN_LEFT : (tilt_sign[0] ? DIR_UP_LEFT : DIR_LEFT);
        end else if (pan_sign[0]) begin
            o_set.dir = tilt_sign[1] ? DIR_DOWN_RIGHT :
                        (tilt_sign[0] ? DIR_UP_RIGHT : DIR_RIGHT);
        end else begin
            o_set.dir = tilt_sign[1] ? DIR_DOWN : (tilt_sign[0] ? DIR_UP : DIR_STOP);
        end
        if (hat[0]) begin
            o_set.zoom = ZOOM_TELE;
        end else if (hat[2]) begin
            o_set.zoom = ZOOM_WIDE;
        end else begin
            o_set.zoom = ZOOM_STOP;
        end
        if (recall_idx == 4'd1) begin
            o_set.preset = r_home_preset;
        end else begin
            o_set.preset = PRESET_W'(recall_idx - 4'd2);
        end
    end

    assign o_push = accept && (o_set.mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_preset  <= '0;
            r_prev_pan     <= '0;
            r_prev_tilt    <= '0;
            r_prev_speed   <= '0;
            r_prev_hat     <= '0;
            r_prev_buttons <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_home_preset <= i_cfg_wr_data;
            end
            if (accept) begin
                r_prev_pan     <= pan;
                r_prev_tilt    <= tilt;
                r_prev_speed   <= speed;
                r_prev_hat     <= hat;
                r_prev_buttons <= buttons;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/jptz_fifo.sv */
// Short register queue of command sets between the front and back ends.
`default_nettype none
module jptz_fifo
    import jptz_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_cmd_set i_set,
    input  wire logic     i_pop,
    output      t_cmd_set o_set,
    output      logic     o_full,
    output      logic     o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd_set         r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]) &&
                     (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W]);
    assign o_set   = r_mem[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/jptz_back.sv */
// Back end: serializes each command set into single commands on a registered output.
`default_nettype none
module jptz_back
    import jptz_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cmd_set               i_set,
    input  wire logic                   i_q_empty,
    output      logic                   o_pop,
    output      logic                   o_valid,
    input  wire logic                   i_ready,
    output      logic [OUT_DATA_W-1:0]  o_data,
    output      logic [KIND_W-1:0]      o_user,
    output      logic                   o_last
);

    t_cmd_set              r_rec;
    logic [CMD_SLOTS-1:0]  r_pend;
    logic                  r_ov;
    logic [KIND_W-1:0]     r_kind;
    logic [DIR_W-1:0]      r_dir;
    logic [SPEED_W-1:0]    r_speed;
    logic [ZOOM_W-1:0]     r_zoom;
    logic [PRESET_W-1:0]   r_preset;
    logic                  r_last;

    logic                  can_adv;
    logic                  emit;
    logic [CMD_SLOTS-1:0]  low_bit;
    logic [CMD_SLOTS-1:0]  pend_left;
    logic                  n_ov;
    logic [KIND_W-1:0]     n_kind;
    logic [DIR_W-1:0]      n_dir;
    logic [SPEED_W-1:0]    n_speed;
    logic [ZOOM_W-1:0]     n_zoom;
    logic [PRESET_W-1:0]   n_preset;

    assign can_adv   = !r_ov || i_ready;
    assign emit      = can_adv && (r_pend != '0);
    assign low_bit   = r_pend & (~r_pend + 1'b1);
    assign pend_left = emit ? (r_pend & ~low_bit) : r_pend;
    assign o_pop     = (pend_left == '0) && !i_q_empty;

    always_comb begin
        n_kind   = KIND_ROTATE;
        n_dir    = '0;
        n_speed  = '0;
        n_zoom   = '0;
        n_preset = '0;
        if (low_bit[SLOT_ROTATE]) begin
            n_kind  = KIND_ROTATE;
            n_dir   = r_rec.dir;
            n_speed = r_rec.speed;
        end else if (low_bit[SLOT_ZOOM]) begin
            n_kind = KIND_ZOOM;
            n_zoom = r_rec.zoom;
        end else if (low_bit[SLOT_STOP]) begin
            n_kind = KIND_STOP;
        end else begin
            n_kind   = KIND_RECALL;
            n_preset = r_rec.preset;
        end
        n_ov = emit ? 1'b1 : (can_adv ? 1'b0 : r_ov);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_ov   <= n_ov;
            r_pend <= o_pop ? i_set.mask : pend_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_set;
        end
        if (emit) begin
            r_kind   <= n_kind;
            r_dir    <= n_dir;
            r_speed  <= n_speed;
            r_zoom   <= n_zoom;
            r_preset <= n_preset;
            r_last   <= (pend_left == '0);
        end
    end

    assign o_valid = r_ov;
    assign o_user  = r_kind;
    assign o_last  = r_last;
    assign o_data  = {{(OUT_DATA_W - DIR_W - SPEED_W - ZOOM_W - PRESET_W){1'b0}},
                      r_preset, r_zoom, r_speed, r_dir};

endmodule
`default_nettype wire

/* rtl/core/joystick_ptz_command_translator_top.sv */
// Top level of the joystick to PTZ command translator.
//
//   Channel  Direction  Ports                          Content
//   s        in         i_s_tvalid/o_s_tready/i_s_tdata  one joystick poll
//   m        out        o_m_tvalid/i_m_tready/o_m_*    one camera command
//   cfg      in         i_cfg_wr_en/i_cfg_wr_data      default preset register
//
// A poll is accepted in any cycle in which the command queue has room; the
// front end compares it with the previous poll in that same cycle.
// The back end sends one command per cycle while the output is ready, one for
// each command a poll causes; a poll causing none sends nothing to the output.
// Synchronous active-low reset clears the previous poll, the register and the queue.
// A stalled output holds its command while polls keep filling the queue.
`default_nettype none
module joystick_ptz_command_translator_top
    import jptz_pkg::*;
#(
    parameter int BUTTON_COUNT = DEF_BUTTON_COUNT,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [PRESET_W-1:0]    i_cfg_wr_data,
    input  wire logic                   i_s_tvalid,
    output      logic                   o_s_tready,
    // pan_axis, tilt_axis, throttle_axis, hat_bits, button_bits
    input  wire logic [IN_DATA_W-1:0]   i_s_tdata,
    output      logic                   o_m_tvalid,
    input  wire logic                   i_m_tready,
    // rotate_direction, rotate_speed, zoom_direction, preset_number, zero pad
    output      logic [OUT_DATA_W-1:0]  o_m_tdata,
    // command_kind
    output      logic [KIND_W-1:0]      o_m_tuser,
    output      logic                   o_m_tlast
);

    t_cmd_set front_set;
    t_cmd_set head_set;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    jptz_front #(
        .BUTTON_COUNT(BUTTON_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_data        (i_s_tdata),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_set         (front_set)
    );

    jptz_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_set   (front_set),
        .i_pop   (pop),
        .o_set   (head_set),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    jptz_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_set     (head_set),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_user    (o_m_tuser),
        .o_last    (o_m_tlast)
    );

endmodule
`default_nettype wire
